// ----- rtl/ioc_pkg.sv -----
// Shared types and codes for the in-order completion ring.
// Used by the channel interface users and the top level; no dependencies.
package ioc_pkg;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_MARK  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_READY = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_READY = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  slot_index;
    logic [1:0]  new_state;
    logic [31:0] payload_in;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [31:0] payload_out;
    logic [4:0]  used_count;
    logic [4:0]  ring_length;
  } rsp_word_t;

  typedef logic [4:0] cfg_word_t;

endpackage

// ----- rtl/ioc_stream.sv -----
// Valid/ready channel carrying one word of a given type.
// Used for the request, result and configuration ports; no dependencies.
interface ioc_stream #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ioc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ioc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/in_order_completion_ring_unit.sv -----
// In-order completion ring (reorder buffer): top level.
// Depends on ioc_pkg, the ioc_stream interface and ioc_ram.
//
// Each request has an accept step and an execute step. On acceptance the
// slot-state memory is read at the write pointer (alloc), the read pointer
// (read) or the addressed slot (mark), and the payload memory at the read
// pointer. The execute step waits until the output register is free or being
// drained; it updates the slot, writes it back and loads the result word into
// the output register. A new request is taken only once the previous one has
// left the execute step, even while its result word still waits to be taken.
// After reset a sweep writes idle into every slot-state entry; requests are
// not taken during it. Configuration writes are taken in every cycle.
module in_order_completion_ring_unit
  import ioc_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  ioc_stream.sink         req,
  ioc_stream.sink         cfg,
  ioc_stream.source       rsp
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int LEN_W = (OCC_W > 5) ? OCC_W : 5;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  // Control state.
  logic             clearing;
  logic [PTR_W-1:0] clr_addr;
  logic             busy;
  logic [PTR_W-1:0] rd_pos, rd_pos_next;
  logic [PTR_W-1:0] wr_pos, wr_pos_next;
  logic [OCC_W-1:0] occ, occ_next;
  logic [OCC_W-1:0] peak, peak_next;
  logic [4:0]       init_len;
  logic             rsp_valid;

  // Payload registers.
  req_word_t op;
  rsp_word_t rsp_word, rsp_word_next;

  // Memory ports.
  logic                  accept;
  logic                  exec;
  logic [PTR_W-1:0]      st_raddr;
  logic [1:0]            st_rdata;
  logic                  st_we;
  logic [PTR_W-1:0]      st_waddr;
  logic [1:0]            st_wdata;
  logic                  exec_st_we;
  logic [PTR_W-1:0]      exec_st_waddr;
  logic [1:0]            exec_st_wdata;
  logic                  pl_we;
  logic [DATA_WIDTH-1:0] pl_rdata;

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] init_l;
  logic [LEN_W-1:0] peak_l;
  logic             idx_ok;
  logic [PTR_W-1:0] op_idx;

  assign accept = req.valid && req.ready;
  assign exec   = busy && (!rsp_valid || rsp.ready);

  assign req.ready = !clearing && !busy;
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_word;

  always_comb begin
    case (req.data.req_type)
      REQ_ALLOC: st_raddr = wr_pos;
      REQ_READ:  st_raddr = rd_pos;
      default:   st_raddr = PTR_W'(req.data.slot_index);
    endcase
  end

  // The clearing sweep owns the state memory write port until it is done.
  assign st_we    = clearing ? 1'b1 : exec_st_we;
  assign st_waddr = clearing ? clr_addr : exec_st_waddr;
  assign st_wdata = clearing ? ST_IDLE : exec_st_wdata;

  ioc_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (accept),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  ioc_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_payload_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (op_idx),
    .wdata (DATA_WIDTH'(op.payload_in)),
    .re    (accept),
    .raddr (rd_pos),
    .rdata (pl_rdata)
  );

  assign op_idx = PTR_W'(op.slot_index);
  assign idx_ok = 32'(op.slot_index) < DEPTH;

  always_comb begin
    rd_pos_next   = rd_pos;
    wr_pos_next   = wr_pos;
    occ_next      = occ;
    exec_st_we    = 1'b0;
    exec_st_waddr = op_idx;
    exec_st_wdata = op.new_state;
    pl_we         = 1'b0;
    rsp_word_next = '0;
    rsp_word_next.status = STATUS_OK;

    case (op.req_type)
      REQ_ALLOC: begin
        rsp_word_next.slot_out = 4'(wr_pos);
        if (st_rdata == ST_IDLE) begin
          exec_st_we    = exec;
          exec_st_waddr = wr_pos;
          exec_st_wdata = ST_BUSY;
          wr_pos_next   = (wr_pos == PTR_LAST) ? '0 : wr_pos + 1'b1;
          if (occ != OCC_FULL) begin
            occ_next = occ + 1'b1;
          end
        end else begin
          rsp_word_next.status = STATUS_FULL;
        end
      end
      REQ_MARK: begin
        rsp_word_next.slot_out = op.slot_index;
        if (idx_ok && (op.new_state inside {ST_IDLE, ST_BUSY, ST_READY})) begin
          exec_st_we = exec;
          pl_we      = exec && (op.new_state == ST_READY);
        end
      end
      REQ_READ: begin
        rsp_word_next.slot_out = 4'(rd_pos);
        if (st_rdata == ST_READY) begin
          exec_st_we    = exec;
          exec_st_waddr = rd_pos;
          exec_st_wdata = ST_IDLE;
          rsp_word_next.payload_out = 32'(pl_rdata);
          rd_pos_next   = (rd_pos == PTR_LAST) ? '0 : rd_pos + 1'b1;
          if (occ != '0) begin
            occ_next = occ - 1'b1;
          end
        end else begin
          rsp_word_next.status = STATUS_NOT_READY;
        end
      end
      default: begin
        rsp_word_next.slot_out = '0;
      end
    endcase

    peak_next = (occ_next > peak) ? occ_next : peak;

    // Reported length: configured length clamped to 1..DEPTH, raised to peak use.
    init_l = LEN_W'(init_len);
    if (init_l == '0) begin
      len = LEN_W'(1);
    end else if (init_l > LEN_W'(DEPTH)) begin
      len = LEN_W'(DEPTH);
    end else begin
      len = init_l;
    end
    peak_l = LEN_W'(peak_next);
    if (peak_l > len) begin
      len = peak_l;
    end

    rsp_word_next.used_count  = 5'(occ_next);
    rsp_word_next.ring_length = 5'(len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      busy      <= 1'b0;
      rd_pos    <= '0;
      wr_pos    <= '0;
      occ       <= '0;
      peak      <= '0;
      init_len  <= 5'd1;
      rsp_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == PTR_LAST) begin
          clearing <= 1'b0;
        end
      end
      if (cfg.valid) begin
        init_len <= cfg.data;
      end
      if (accept) begin
        busy <= 1'b1;
      end
      if (exec) begin
        busy      <= 1'b0;
        rd_pos    <= rd_pos_next;
        wr_pos    <= wr_pos_next;
        occ       <= occ_next;
        peak      <= peak_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= req.data;
    end
    if (exec) begin
      rsp_word <= rsp_word_next;
    end
  end

endmodule
